@@ rtl/tofc_pkg.sv @@
// ----------------------------------------------------------------------------
// tofc_pkg
// Shared constants, types and the arctangent table of the tilt correction.
// ----------------------------------------------------------------------------
`default_nettype none

package tofc_pkg;

  localparam int MAX_SAMPLES       = 1024;
  localparam int CORDIC_ITERATIONS = 24;

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = 23 + CNT_W;
  localparam int CW     = 34;   // CORDIC word
  localparam int MW     = 51;   // offset products
  localparam int DIVN_W = 54;   // dividend / quotient
  localparam int DIVD_W = 31;   // divisor
  localparam int SQ_W   = 62;   // root radicand
  localparam int ROOT_W = 31;
  localparam int F_W    = 24;

  localparam logic [4:0] ITER_LAST = 5'(CORDIC_ITERATIONS - 1);

  localparam logic signed [CW-1:0]  CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CW-1:0]  TILT_LIMIT  = 34'sd5898240;
  localparam logic signed [F_W-1:0] F_MAX       = 24'sd8388607;
  localparam logic signed [F_W-1:0] F_MIN       = -24'sd8388608;

  typedef enum logic [1:0] {
    REG_OFFSET_X    = 2'd0,
    REG_OFFSET_Y    = 2'd1,
    REG_BODY_RADIUS = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic start;
    logic vect;
  } cordic_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ROT,
    ST_MUL1,
    ST_MUL2,
    ST_DIVS,
    ST_SQ,
    ST_SQRTC,
    ST_VEC,
    ST_DIVD,
    ST_DIVL,
    ST_NSQ1,
    ST_NSQ2,
    ST_SQRTN,
    ST_ACC,
    ST_AVGD,
    ST_AVGL,
    ST_AVGN,
    ST_FIN
  } state_e;

  // atan(2^-i) in degrees, Q.24
  function automatic logic signed [CW-1:0] atan_lut(input logic [4:0] i);
    logic signed [CW-1:0] v;
    begin
      unique case (i)
        5'd0:  v = 34'sd754974720;
        5'd1:  v = 34'sd445687602;
        5'd2:  v = 34'sd235489088;
        5'd3:  v = 34'sd119537938;
        5'd4:  v = 34'sd60000934;
        5'd5:  v = 34'sd30029717;
        5'd6:  v = 34'sd15018523;
        5'd7:  v = 34'sd7509720;
        5'd8:  v = 34'sd3754917;
        5'd9:  v = 34'sd1877466;
        5'd10: v = 34'sd938734;
        5'd11: v = 34'sd469367;
        5'd12: v = 34'sd234684;
        5'd13: v = 34'sd117342;
        5'd14: v = 34'sd58671;
        5'd15: v = 34'sd29335;
        5'd16: v = 34'sd14668;
        5'd17: v = 34'sd7334;
        5'd18: v = 34'sd3667;
        5'd19: v = 34'sd1833;
        5'd20: v = 34'sd917;
        5'd21: v = 34'sd458;
        5'd22: v = 34'sd229;
        5'd23: v = 34'sd115;
        5'd24: v = 34'sd57;
        5'd25: v = 34'sd29;
        5'd26: v = 34'sd14;
        5'd27: v = 34'sd7;
        5'd28: v = 34'sd4;
        5'd29: v = 34'sd2;
        5'd30: v = 34'sd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/tilt_offset_force_correction.sv @@
// ----------------------------------------------------------------------------
// tilt_offset_force_correction
// Tilt correction of force-balance samples with running batch averages.
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tdata: angle_deg, drag_raw, lift_raw; tlast: last_sample
// m_axis    out  tdata: corrected forces, net, tilt, averages; tuser: domain_error;
//                tlast: avg_valid
// cfg       in   cfg_index_i: offset_x, offset_y, body_radius; cfg_data_i 16 bit
//
// A new item is taken only once the last result is loaded into the m_axis register;
// the one-bit-per-cycle divider (three quotients per item, six on an item with tlast)
// dominates its work, then two CORDIC passes and two root passes.
// Reset clears the sums, the count and the registers to their defaults.
// A result waiting on m_axis holds the block only at its final step.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_offset_force_correction (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [63:0]  s_axis_tdata,   // angle_deg[8:0], drag_raw[32:9], lift_raw[56:33]
  input  wire         s_axis_tlast,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [167:0] m_axis_tdata,  // drag_corr, lift_corr, net_force, tilt_deg,
                                      // avg_drag, avg_lift, avg_net
  output logic        m_axis_tuser,   // domain_error
  output logic        m_axis_tlast,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire [1:0]   cfg_index_i,
  input  wire [15:0]  cfg_data_i
);

  localparam int CW = tofc_pkg::CW;
  localparam int MW = tofc_pkg::MW;
  localparam int NW = tofc_pkg::DIVN_W;
  localparam int SW = tofc_pkg::SUM_W;

  tofc_pkg::state_e state_q, state_d;
  logic launch_q, in_op, launch, unit_done;

  logic signed [15:0] ox_q, oy_q;
  logic [15:0]        rad_q;

  logic signed [9:0]  deg_q;
  logic               neg_q, last_q, err_q, sneg_q;
  logic signed [23:0] drag_q, lift_q, dc_q, lc_q, avgd_q, avgl_q;
  logic [22:0]        net_q, avgn_q;
  logic signed [23:0] tilt_q;
  logic signed [CW-1:0] cs_q, sn_q;
  logic signed [MW-1:0] prod_q, num_q;
  logic [30:0]        qs_q, cos_q;
  logic [tofc_pkg::SQ_W-1:0] sqv_q;
  logic [47:0]        nsq_q;
  logic signed [SW-1:0] dsum_q, lsum_q, nsum_q;
  logic [tofc_pkg::CNT_W-1:0] cnt_q;

  logic m_valid_q, load_out;
  logic [167:0] m_data_q;
  logic m_user_q, m_last_q;

  tofc_pkg::cordic_req_t cordic_req;
  logic signed [CW-1:0] c_x, c_y, c_z, c_xi, c_yi, c_zi;
  logic c_done, d_start, d_done, r_start, r_done;
  logic [NW-1:0] d_num, d_quot;
  logic [30:0]   d_den, r_root;
  logic [tofc_pkg::SQ_W-1:0] r_rad;

  logic [8:0] a_in, a_m;
  logic signed [CW-1:0] zr, tl;
  logic signed [MW-1:0] num_mag;
  logic signed [SW-1:0] sum_sel, sum_mag;

  function automatic logic signed [23:0] corr(input logic signed [23:0] raw,
                                              input logic [NW-1:0] q);
    logic signed [23:0] r;
    begin
      if (raw == 24'sd0) r = '0;
      else if (!raw[23]) r = (q > NW'(tofc_pkg::F_MAX)) ? tofc_pkg::F_MAX : 24'(q);
      else r = (q > NW'(24'd8388608)) ? tofc_pkg::F_MIN : 24'(NW'(0) - q);
      return r;
    end
  endfunction

  // config
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q  <= '0;
      oy_q  <= '0;
      rad_q <= 16'd6400;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tofc_pkg::REG_OFFSET_X:    ox_q  <= cfg_data_i;
        tofc_pkg::REG_OFFSET_Y:    oy_q  <= cfg_data_i;
        tofc_pkg::REG_BODY_RADIUS: rad_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == tofc_pkg::ST_IDLE);

  assign in_op = (state_q == tofc_pkg::ST_ROT)   || (state_q == tofc_pkg::ST_VEC)   ||
                 (state_q == tofc_pkg::ST_DIVS)  || (state_q == tofc_pkg::ST_DIVD)  ||
                 (state_q == tofc_pkg::ST_DIVL)  || (state_q == tofc_pkg::ST_AVGD)  ||
                 (state_q == tofc_pkg::ST_AVGL)  || (state_q == tofc_pkg::ST_AVGN)  ||
                 (state_q == tofc_pkg::ST_SQRTC) || (state_q == tofc_pkg::ST_SQRTN);
  assign launch    = in_op && !launch_q;
  assign unit_done = c_done || d_done || r_done;
  assign load_out  = (state_q == tofc_pkg::ST_FIN) && (!m_valid_q || m_axis_tready);

  assign sum_sel = (state_q == tofc_pkg::ST_AVGD) ? dsum_q :
                   (state_q == tofc_pkg::ST_AVGL) ? lsum_q : nsum_q;
  assign sum_mag = sum_sel[SW-1] ? -sum_sel : sum_sel;
  assign num_mag = num_q[MW-1] ? -num_q : num_q;

  // unit operand selection
  always_comb begin
    cordic_req.start = 1'b0;
    cordic_req.vect  = 1'b0;
    d_start = 1'b0;
    r_start = 1'b0;
    c_xi    = $signed({3'b000, cos_q});
    c_yi    = sneg_q ? -$signed({3'b000, qs_q}) : $signed({3'b000, qs_q});
    c_zi    = CW'(deg_q) <<< 24;
    d_num   = NW'($unsigned(num_mag));
    d_den   = (rad_q == 16'd0) ? 31'd1 : 31'(rad_q);
    r_rad   = sqv_q;
    unique case (state_q)
      tofc_pkg::ST_ROT:   cordic_req.start = launch;
      tofc_pkg::ST_VEC: begin
        cordic_req.start = launch;
        cordic_req.vect  = 1'b1;
      end
      tofc_pkg::ST_DIVS:  d_start = launch;
      tofc_pkg::ST_DIVD: begin
        d_start = launch;
        d_num   = NW'(drag_q[23] ? -25'(drag_q) : 25'(drag_q)) << 30;
        d_den   = cos_q;
      end
      tofc_pkg::ST_DIVL: begin
        d_start = launch;
        d_num   = NW'(lift_q[23] ? -25'(lift_q) : 25'(lift_q)) << 30;
        d_den   = cos_q;
      end
      tofc_pkg::ST_AVGD, tofc_pkg::ST_AVGL, tofc_pkg::ST_AVGN: begin
        d_start = launch;
        d_num   = NW'($unsigned(sum_mag));
        d_den   = 31'(cnt_q);
      end
      tofc_pkg::ST_SQRTC: r_start = launch;
      tofc_pkg::ST_SQRTN: begin
        r_start = launch;
        r_rad   = tofc_pkg::SQ_W'(nsq_q);
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tofc_pkg::ST_IDLE:  if (s_axis_tvalid) state_d = tofc_pkg::ST_ROT;
      tofc_pkg::ST_ROT:   if (launch_q && unit_done) state_d = tofc_pkg::ST_MUL1;
      tofc_pkg::ST_MUL1:  state_d = tofc_pkg::ST_MUL2;
      tofc_pkg::ST_MUL2:  state_d = tofc_pkg::ST_DIVS;
      tofc_pkg::ST_DIVS:  if (launch_q && unit_done) state_d = tofc_pkg::ST_SQ;
      tofc_pkg::ST_SQ:    state_d = tofc_pkg::ST_SQRTC;
      tofc_pkg::ST_SQRTC: if (launch_q && unit_done) state_d = tofc_pkg::ST_VEC;
      tofc_pkg::ST_VEC:   if (launch_q && unit_done) state_d = tofc_pkg::ST_DIVD;
      tofc_pkg::ST_DIVD:  if (launch_q && unit_done) state_d = tofc_pkg::ST_DIVL;
      tofc_pkg::ST_DIVL:  if (launch_q && unit_done) state_d = tofc_pkg::ST_NSQ1;
      tofc_pkg::ST_NSQ1:  state_d = tofc_pkg::ST_NSQ2;
      tofc_pkg::ST_NSQ2:  state_d = tofc_pkg::ST_SQRTN;
      tofc_pkg::ST_SQRTN: if (launch_q && unit_done) state_d = tofc_pkg::ST_ACC;
      tofc_pkg::ST_ACC:   state_d = last_q ? tofc_pkg::ST_AVGD : tofc_pkg::ST_FIN;
      tofc_pkg::ST_AVGD:  if (launch_q && unit_done) state_d = tofc_pkg::ST_AVGL;
      tofc_pkg::ST_AVGL:  if (launch_q && unit_done) state_d = tofc_pkg::ST_AVGN;
      tofc_pkg::ST_AVGN:  if (launch_q && unit_done) state_d = tofc_pkg::ST_FIN;
      tofc_pkg::ST_FIN:   if (load_out) state_d = tofc_pkg::ST_IDLE;
      default:            state_d = tofc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tofc_pkg::ST_IDLE;
      launch_q  <= 1'b0;
      m_valid_q <= 1'b0;
      dsum_q    <= '0;
      lsum_q    <= '0;
      nsum_q    <= '0;
      cnt_q     <= '0;
    end else begin
      state_q <= state_d;
      if (launch) launch_q <= 1'b1;
      else if (unit_done) launch_q <= 1'b0;
      if (load_out) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
      if (state_q == tofc_pkg::ST_ACC && cnt_q < tofc_pkg::CNT_W'(tofc_pkg::MAX_SAMPLES)) begin
        dsum_q <= dsum_q + SW'(dc_q);
        lsum_q <= lsum_q + SW'(lc_q);
        nsum_q <= nsum_q + SW'({1'b0, net_q});
        cnt_q  <= cnt_q + tofc_pkg::CNT_W'(1);
      end
      if (load_out && last_q) begin
        dsum_q <= '0;
        lsum_q <= '0;
        nsum_q <= '0;
        cnt_q  <= '0;
      end
    end
  end

  assign a_in = s_axis_tdata[8:0];
  assign a_m  = (a_in >= 9'd360) ? a_in - 9'd360 : a_in;
  assign zr   = c_z + CW'(128);
  assign tl   = zr >>> 8;

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      tofc_pkg::ST_IDLE: if (s_axis_tvalid) begin
        drag_q <= s_axis_tdata[32:9];
        lift_q <= s_axis_tdata[56:33];
        last_q <= s_axis_tlast;
        avgd_q <= '0;
        avgl_q <= '0;
        avgn_q <= '0;
        if (a_m > 9'd270) begin
          deg_q <= $signed({1'b0, a_m}) - 10'sd360;
          neg_q <= 1'b0;
        end else if (a_m > 9'd90) begin
          deg_q <= $signed({1'b0, a_m}) - 10'sd180;
          neg_q <= 1'b1;
        end else begin
          deg_q <= $signed({1'b0, a_m});
          neg_q <= 1'b0;
        end
      end
      tofc_pkg::ST_ROT: if (c_done) begin
        cs_q <= neg_q ? -c_x : c_x;
        sn_q <= neg_q ? -c_y : c_y;
      end
      tofc_pkg::ST_MUL1: prod_q <= MW'(ox_q) * MW'(sn_q);
      tofc_pkg::ST_MUL2: num_q  <= prod_q + MW'(oy_q) * MW'(cs_q);
      tofc_pkg::ST_DIVS: if (d_done) begin
        sneg_q <= num_q[MW-1];
        if (d_quot > (NW'(1) << 30)) begin
          qs_q  <= 31'd1 << 30;
          err_q <= 1'b1;
        end else begin
          qs_q  <= 31'(d_quot);
          err_q <= 1'b0;
        end
      end
      tofc_pkg::ST_SQ:
        sqv_q <= (tofc_pkg::SQ_W'(1) << 60) - tofc_pkg::SQ_W'(qs_q) * tofc_pkg::SQ_W'(qs_q);
      tofc_pkg::ST_SQRTC: if (r_done) cos_q <= r_root;
      tofc_pkg::ST_VEC: if (c_done) begin
        if (tl > tofc_pkg::TILT_LIMIT)       tilt_q <= 24'(tofc_pkg::TILT_LIMIT);
        else if (tl < -tofc_pkg::TILT_LIMIT) tilt_q <= 24'(-tofc_pkg::TILT_LIMIT);
        else                                 tilt_q <= 24'(tl);
      end
      tofc_pkg::ST_DIVD: if (d_done) dc_q <= corr(drag_q, d_quot);
      tofc_pkg::ST_DIVL: if (d_done) lc_q <= corr(lift_q, d_quot);
      tofc_pkg::ST_NSQ1: nsq_q <= $unsigned(48'(dc_q) * 48'(dc_q));
      tofc_pkg::ST_NSQ2: nsq_q <= nsq_q + $unsigned(48'(lc_q) * 48'(lc_q));
      tofc_pkg::ST_SQRTN: if (r_done)
        net_q <= (r_root > 31'd8388607) ? 23'd8388607 : 23'(r_root);
      tofc_pkg::ST_AVGD: if (d_done) avgd_q <= dsum_q[SW-1] ? 24'(NW'(0) - d_quot) : 24'(d_quot);
      tofc_pkg::ST_AVGL: if (d_done) avgl_q <= lsum_q[SW-1] ? 24'(NW'(0) - d_quot) : 24'(d_quot);
      tofc_pkg::ST_AVGN: if (d_done) avgn_q <= 23'(d_quot);
      default: ;
    endcase
    if (load_out) begin
      m_data_q <= {2'b00, avgn_q, avgl_q, avgd_q, tilt_q, net_q, lc_q, dc_q};
      m_user_q <= err_q;
      m_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

  tofc_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cordic_req),
    .x_i    (c_xi),
    .y_i    (c_yi),
    .z_i    (c_zi),
    .done_o (c_done),
    .x_o    (c_x),
    .y_o    (c_y),
    .z_o    (c_z)
  );

  tofc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (d_start),
    .dividend_i (d_num),
    .divisor_i  (d_den),
    .done_o     (d_done),
    .quot_o     (d_quot)
  );

  tofc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (r_start),
    .rad_i   (r_rad),
    .done_o  (r_done),
    .root_o  (r_root)
  );

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= tofc_pkg::CNT_W'(tofc_pkg::MAX_SAMPLES))
    else $error("sample count beyond batch limit");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while previous one in flight");

  a_one_unit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({c_done, d_done, r_done}) <= 1)
    else $error("two arithmetic units finished together");

  a_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tofc_pkg::ST_VEC |-> cos_q <= (31'd1 << 30))
    else $error("cosine above one");

endmodule

`default_nettype wire

@@ rtl/tofc_cordic.sv @@
// ----------------------------------------------------------------------------
// tofc_cordic
// One-step-per-cycle CORDIC, rotation or vectoring mode, degrees Q.24.
// ----------------------------------------------------------------------------
`default_nettype none

module tofc_cordic (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire tofc_pkg::cordic_req_t          req_i,
  input  wire logic signed [tofc_pkg::CW-1:0] x_i,
  input  wire logic signed [tofc_pkg::CW-1:0] y_i,
  input  wire logic signed [tofc_pkg::CW-1:0] z_i,
  output logic                                done_o,
  output logic signed [tofc_pkg::CW-1:0]      x_o,
  output logic signed [tofc_pkg::CW-1:0]      y_o,
  output logic signed [tofc_pkg::CW-1:0]      z_o
);

  logic signed [tofc_pkg::CW-1:0] x_q, y_q, z_q, dx, dy, a;
  logic [4:0] i_q;
  logic       busy_q, vect_q, done_q, pos;

  assign dx  = y_q >>> i_q;
  assign dy  = x_q >>> i_q;
  assign a   = tofc_pkg::atan_lut(i_q);
  assign pos = vect_q ? y_q[tofc_pkg::CW-1] : !z_q[tofc_pkg::CW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      vect_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        vect_q <= req_i.vect;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 5'd1;
        if (i_q == tofc_pkg::ITER_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q <= req_i.vect ? x_i : tofc_pkg::CORDIC_GAIN;
      y_q <= req_i.vect ? y_i : '0;
      z_q <= req_i.vect ? '0 : z_i;
    end else if (busy_q) begin
      if (pos) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - a;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + a;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

`default_nettype wire

@@ rtl/tofc_div.sv @@
// ----------------------------------------------------------------------------
// tofc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tofc_div (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  input  wire [tofc_pkg::DIVN_W-1:0]       dividend_i,
  input  wire [tofc_pkg::DIVD_W-1:0]       divisor_i,
  output logic                             done_o,
  output logic [tofc_pkg::DIVN_W-1:0]      quot_o
);

  logic [tofc_pkg::DIVN_W-1:0] quot_q;
  logic [tofc_pkg::DIVD_W-1:0] div_q, rem_q;
  logic [tofc_pkg::DIVD_W:0]   rem_sh;
  logic [5:0] cnt_q;
  logic       busy_q, done_q, ge;

  assign rem_sh = {rem_q, quot_q[tofc_pkg::DIVN_W-1]};
  assign ge     = rem_sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(tofc_pkg::DIVN_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      div_q  <= divisor_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      quot_q <= {quot_q[tofc_pkg::DIVN_W-2:0], ge};
      rem_q  <= ge ? tofc_pkg::DIVD_W'(rem_sh - {1'b0, div_q})
                   : tofc_pkg::DIVD_W'(rem_sh);
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

@@ rtl/tofc_sqrt.sv @@
// ----------------------------------------------------------------------------
// tofc_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tofc_sqrt (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  input  wire [tofc_pkg::SQ_W-1:0]         rad_i,
  output logic                             done_o,
  output logic [tofc_pkg::ROOT_W-1:0]      root_o
);

  logic [tofc_pkg::SQ_W-1:0] v_q, r_q, b_q, t;
  logic busy_q, done_q;

  assign t = r_q + b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && b_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= rad_i;
      r_q <= '0;
      b_q <= tofc_pkg::SQ_W'(1) << (tofc_pkg::SQ_W - 2);
    end else if (busy_q) begin
      if (v_q >= t) begin
        v_q <= v_q - t;
        r_q <= (r_q >> 1) + b_q;
      end else begin
        r_q <= r_q >> 1;
      end
      b_q <= b_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[tofc_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire
